>>> src/c_lex_pkg.sv
// ----------------------------------------------------------------------------
// C subset lexer package
// Request and result types, character codes, token kinds and lookup helpers.
// ----------------------------------------------------------------------------
package c_lex_pkg;

   localparam int CNT_W  = 20;
   localparam int OFF_W  = 24;
   localparam int VAL_W  = 64;
   localparam int KIND_W = 6;
   localparam int ERR_W  = 3;
   localparam int SLOTS  = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // token kinds
   localparam logic [KIND_W-1:0] KIND_END      = 6'd0;
   localparam logic [KIND_W-1:0] KIND_INT      = 6'd1;
   localparam logic [KIND_W-1:0] KIND_STRING   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd3;
   localparam logic [KIND_W-1:0] KIND_SINGLE   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_EQ       = 6'd5;
   localparam logic [KIND_W-1:0] KIND_NE       = 6'd6;
   localparam logic [KIND_W-1:0] KIND_LE       = 6'd7;
   localparam logic [KIND_W-1:0] KIND_GE       = 6'd8;
   localparam logic [KIND_W-1:0] KIND_LAND     = 6'd9;
   localparam logic [KIND_W-1:0] KIND_LOR      = 6'd10;
   localparam logic [KIND_W-1:0] KIND_INC      = 6'd11;
   localparam logic [KIND_W-1:0] KIND_DEC      = 6'd12;
   localparam logic [KIND_W-1:0] KIND_ADD_EQ   = 6'd13;
   localparam logic [KIND_W-1:0] KIND_SUB_EQ   = 6'd14;
   localparam logic [KIND_W-1:0] KIND_MUL_EQ   = 6'd15;
   localparam logic [KIND_W-1:0] KIND_DIV_EQ   = 6'd16;
   localparam logic [KIND_W-1:0] KIND_ARROW    = 6'd17;
   localparam logic [KIND_W-1:0] KIND_KW_BASE  = 6'd18;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_COMMENT   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_CHAR      = 3'd2;
   localparam logic [ERR_W-1:0] ERR_STRING    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd4;

   // character codes
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_QUOTE  = "'";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_ZERO   = "0";

   localparam int NUM_KW = 18;

   // keywords, left aligned, first character in the top byte
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      {"return", 16'h0}, {"for", 40'h0}, {"while", 24'h0}, {"if", 48'h0},
      {"else", 32'h0}, {"int", 40'h0}, {"void", 32'h0}, {"char", 32'h0},
      {"short", 24'h0}, {"long", 32'h0}, "unsigned", {"signed", 16'h0},
      {"break", 24'h0}, "continue", {"sizeof", 16'h0}, {"struct", 16'h0},
      {"union", 24'h0}, {"enum", 32'h0}
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } lex_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [VAL_W-1:0]  value;
      logic [CNT_W-1:0]  line;
      logic [CNT_W-1:0]  column;
      logic [OFF_W-1:0]  start_offset;
      logic [OFF_W-1:0]  length;
      logic [ERR_W-1:0]  error_code;
      logic              last_of_run;
   } lex_rsp_type;

   // results of one byte, in order
   typedef struct packed {
      lex_rsp_type [SLOTS-1:0] item;
      logic [1:0]              count;
   } lex_batch_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == "_");
   endfunction

   function automatic logic is_single(input logic [7:0] b);
      return b inside {"+", "-", "*", "/", "%", "(", ")", "=", ";", ",", "<", ">",
                       "{", "}", "&", "[", "]", "?", ":", ".", "!"};
   endfunction

   function automatic logic is_pair_first(input logic [7:0] b);
      return b inside {"=", "!", "<", ">", "&", "|", "+", "-", "*", "/"};
   endfunction

   // two-character operator kind, zero when the pair is not an operator
   function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a,
                                                   input logic [7:0] b);
      logic [KIND_W-1:0] k;
      k = KIND_END;
      case ({a, b})
         "==":    k = KIND_EQ;
         "!=":    k = KIND_NE;
         "<=":    k = KIND_LE;
         ">=":    k = KIND_GE;
         "&&":    k = KIND_LAND;
         "||":    k = KIND_LOR;
         "++":    k = KIND_INC;
         "--":    k = KIND_DEC;
         "+=":    k = KIND_ADD_EQ;
         "-=":    k = KIND_SUB_EQ;
         "*=":    k = KIND_MUL_EQ;
         "/=":    k = KIND_DIV_EQ;
         "->":    k = KIND_ARROW;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] b);
      logic [7:0] v;
      case (b)
         "n":     v = 8'd10;
         "t":     v = 8'd9;
         "r":     v = 8'd13;
         "v":     v = 8'd11;
         "f":     v = 8'd12;
         "a":     v = 8'd7;
         "b":     v = 8'd8;
         default: v = b;
      endcase
      return v;
   endfunction

   // keyword kind for a left-aligned name head, identifier kind otherwise
   function automatic logic [KIND_W-1:0] keyword_kind(input logic [63:0] head);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < NUM_KW; i++) begin
         if (head == KW_TEXT[i]) begin
            k = KIND_KW_BASE + KIND_W'(i);
         end
      end
      return k;
   endfunction

endpackage

>>> src/c_subset_lexer.sv
// Flow: a request is registered in the input register, lexed once the result
//   buffer has room, and its results are then offered from the result buffer.
// Throughput: one byte per cycle while each byte gives at most one result and
//   rsp_stall is low; a byte with more results holds the input until only its last is left.
// Reset: synchronous, active high; clears the lexer to idle at line 1, column 1.
// ----------------------------------------------------------------------------
// C subset lexer
// Byte-serial lexer for a small C subset with line and column tracking.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
   parameter int MAX_KEYWORD_CHARS = 8,
   parameter int POSITION_BITS     = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  c_lex_pkg::lex_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output c_lex_pkg::lex_rsp_type rsp_data
);

   logic                     room;
   logic                     advance;
   c_lex_pkg::lex_req_type   held;
   c_lex_pkg::lex_batch_type batch;

   c_lex_inreg u_inreg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .room      (room),
      .advance   (advance),
      .held      (held)
   );

   c_lex_step #(
      .MAX_KEYWORD_CHARS (MAX_KEYWORD_CHARS),
      .POSITION_BITS     (POSITION_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (held),
      .batch   (batch)
   );

   c_lex_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .batch     (batch),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a request only waits behind pending results
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("stall without pending result");

   // results of one byte leave without a gap
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_of_run) |=> rsp_valid)
      else $error("result run broken");

   // an end-of-text byte always produces results
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && held.is_last) |-> (batch.count != 2'd0))
      else $error("end of text without end token");
`endif

endmodule

>>> src/c_lex_step.sv
// ----------------------------------------------------------------------------
// C subset lexer step
// Lexer state registers and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module c_lex_step #(
   parameter int MAX_KEYWORD_CHARS = 8,
   parameter int POSITION_BITS     = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  c_lex_pkg::lex_req_type  req,
   output c_lex_pkg::lex_batch_type batch
);

   localparam int P    = POSITION_BITS;
   localparam int KB_W = 8 * MAX_KEYWORD_CHARS;
   localparam int KL_W = $clog2(MAX_KEYWORD_CHARS + 2);
   localparam int CW   = c_lex_pkg::CNT_W;

   localparam logic [KL_W-1:0] KL_MAX  = KL_W'(MAX_KEYWORD_CHARS);
   localparam logic [KL_W-1:0] KL_OVER = KL_W'(MAX_KEYWORD_CHARS + 1);

   localparam logic [3:0] M_IDLE       = 4'd0;
   localparam logic [3:0] M_SLASH      = 4'd1;
   localparam logic [3:0] M_LINE_CMT   = 4'd2;
   localparam logic [3:0] M_BLOCK      = 4'd3;
   localparam logic [3:0] M_BLOCK_STAR = 4'd4;
   localparam logic [3:0] M_NUMBER     = 4'd5;
   localparam logic [3:0] M_IDENT      = 4'd6;
   localparam logic [3:0] M_CHAR_OPEN  = 4'd7;
   localparam logic [3:0] M_CHAR_ESC   = 4'd8;
   localparam logic [3:0] M_CHAR_CLOSE = 4'd9;
   localparam logic [3:0] M_STRING     = 4'd10;
   localparam logic [3:0] M_OPFIRST    = 4'd11;

   logic [3:0]      mode_ff, mode_in;
   logic [CW-1:0]   line_ff, line_in, col_ff, col_in;
   logic [CW-1:0]   tline_ff, tline_in, tcol_ff, tcol_in;
   logic [P-1:0]    off_ff, off_in, tstart_ff, tstart_in;
   logic [63:0]     acc_ff, acc_in;
   logic [7:0]      held_ff, held_in, prev_ff, prev_in;
   logic [KB_W-1:0] kbuf_ff, kbuf_in;
   logic [KL_W-1:0] klen_ff, klen_in;

   logic [7:0]      b;
   logic            go_idle;
   logic [CW-1:0]   end_line, end_col;
   logic [c_lex_pkg::KIND_W-1:0] id_kind;
   c_lex_pkg::lex_rsp_type [3:0] ev;
   logic [3:0]      ev_vld;
   logic [1:0]      n;

   function automatic c_lex_pkg::lex_rsp_type make_rsp(
      input logic [c_lex_pkg::KIND_W-1:0] kind,
      input logic [63:0]                  value,
      input logic [CW-1:0]                ln,
      input logic [CW-1:0]                cl,
      input logic [P-1:0]                 st,
      input logic [P-1:0]                 len,
      input logic [c_lex_pkg::ERR_W-1:0]  err);
      c_lex_pkg::lex_rsp_type r;
      r.kind         = kind;
      r.value        = value;
      r.line         = ln;
      r.column       = cl;
      r.start_offset = c_lex_pkg::OFF_W'(st);
      r.length       = c_lex_pkg::OFF_W'(len);
      r.error_code   = err;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == c_lex_pkg::CNT_MAX) ? v : v + CW'(1);
   endfunction

   // keyword lookup on the stored name head; overlong names stay identifiers
   function automatic logic [c_lex_pkg::KIND_W-1:0] ident_kind(
      input logic [KB_W-1:0] kb, input logic [KL_W-1:0] kl);
      logic [KB_W-1:0] rest;
      rest = kb << 64;
      if (kl <= KL_MAX && rest == '0) begin
         return c_lex_pkg::keyword_kind(kb[KB_W-1 -: 64]);
      end
      return c_lex_pkg::KIND_IDENT;
   endfunction

   assign id_kind = ident_kind(kbuf_ff, klen_ff);

   // next state and tokens for one byte
   always_comb begin
      b         = req.in_byte;
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      off_in    = off_ff;
      tstart_in = tstart_ff;
      acc_in    = acc_ff;
      held_in   = held_ff;
      prev_in   = prev_ff;
      kbuf_in   = kbuf_ff;
      klen_in   = klen_ff;
      go_idle   = 1'b0;
      ev        = '0;
      ev_vld    = '0;
      end_line  = '0;
      end_col   = '0;

      // continue the token in progress
      case (mode_ff)
         M_SLASH: begin
            if (b == c_lex_pkg::CH_SLASH) begin
               mode_in = M_LINE_CMT;
            end else if (b == c_lex_pkg::CH_STAR) begin
               mode_in = M_BLOCK;
            end else begin
               mode_in = M_IDLE;
               col_in  = sat_inc(col_in);
               ev_vld[0] = 1'b1;
               if (b == c_lex_pkg::CH_EQUAL) begin
                  col_in = sat_inc(col_in);
                  ev[0]  = make_rsp(c_lex_pkg::KIND_DIV_EQ, '0, tline_ff, tcol_ff,
                                    tstart_ff, '0, c_lex_pkg::ERR_NONE);
               end else begin
                  ev[0]   = make_rsp(c_lex_pkg::KIND_SINGLE, 64'(c_lex_pkg::CH_SLASH),
                                     tline_ff, tcol_ff, tstart_ff, '0,
                                     c_lex_pkg::ERR_NONE);
                  go_idle = 1'b1;
               end
            end
         end
         M_LINE_CMT: begin
            if (b == c_lex_pkg::CH_NL) begin
               mode_in = M_IDLE;
               go_idle = 1'b1;
            end
         end
         M_BLOCK: begin
            if (b == c_lex_pkg::CH_STAR) begin
               mode_in = M_BLOCK_STAR;
            end
         end
         M_BLOCK_STAR: begin
            if (b == c_lex_pkg::CH_SLASH) begin
               mode_in = M_IDLE;
            end else if (b != c_lex_pkg::CH_STAR) begin
               mode_in = M_BLOCK;
            end
         end
         M_NUMBER: begin
            if (c_lex_pkg::is_digit(b)) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + 64'(b - c_lex_pkg::CH_ZERO);
               col_in = sat_inc(col_in);
            end else begin
               ev_vld[0] = 1'b1;
               ev[0]     = make_rsp(c_lex_pkg::KIND_INT, acc_ff, tline_ff, tcol_ff,
                                    tstart_ff, '0, c_lex_pkg::ERR_NONE);
               mode_in   = M_IDLE;
               go_idle   = 1'b1;
            end
         end
         M_IDENT: begin
            if (c_lex_pkg::is_alpha(b) || c_lex_pkg::is_digit(b)) begin
               if (klen_ff < KL_MAX) begin
                  for (int i = 0; i < MAX_KEYWORD_CHARS; i++) begin
                     if (klen_ff == KL_W'(i)) begin
                        kbuf_in[KB_W-1-8*i -: 8] = b;
                     end
                  end
                  klen_in = klen_ff + KL_W'(1);
               end else begin
                  klen_in = KL_OVER;
               end
               col_in = sat_inc(col_in);
            end else begin
               ev_vld[0] = 1'b1;
               ev[0]     = make_rsp(id_kind, '0, tline_ff, tcol_ff, tstart_ff,
                                    off_ff - tstart_ff, c_lex_pkg::ERR_NONE);
               mode_in   = M_IDLE;
               go_idle   = 1'b1;
            end
         end
         M_CHAR_OPEN: begin
            col_in = sat_inc(col_in);
            if (b == c_lex_pkg::CH_BSLASH) begin
               mode_in = M_CHAR_ESC;
            end else begin
               acc_in  = 64'(b);
               mode_in = M_CHAR_CLOSE;
            end
         end
         M_CHAR_ESC: begin
            col_in  = sat_inc(col_in);
            acc_in  = 64'(c_lex_pkg::escape_value(b));
            mode_in = M_CHAR_CLOSE;
         end
         M_CHAR_CLOSE: begin
            col_in    = sat_inc(col_in);
            ev_vld[0] = 1'b1;
            if (b == c_lex_pkg::CH_QUOTE) begin
               ev[0] = make_rsp(c_lex_pkg::KIND_INT, acc_ff, tline_ff, tcol_ff,
                                tstart_ff, '0, c_lex_pkg::ERR_NONE);
            end else begin
               ev[0] = make_rsp(c_lex_pkg::KIND_END, 64'(b), tline_ff, tcol_ff,
                                tstart_ff, '0, c_lex_pkg::ERR_CHAR);
            end
            mode_in = M_IDLE;
         end
         M_STRING: begin
            col_in = sat_inc(col_in);
            if (b == c_lex_pkg::CH_DQUOTE && prev_ff != c_lex_pkg::CH_BSLASH) begin
               ev_vld[0] = 1'b1;
               ev[0]     = make_rsp(c_lex_pkg::KIND_STRING, '0, tline_ff, tcol_ff,
                                    tstart_ff + P'(1), off_ff - tstart_ff - P'(1),
                                    c_lex_pkg::ERR_NONE);
               mode_in   = M_IDLE;
            end
         end
         M_OPFIRST: begin
            mode_in = M_IDLE;
            ev_vld[0] = 1'b1;
            if (c_lex_pkg::pair_kind(held_ff, b) != c_lex_pkg::KIND_END) begin
               col_in = sat_inc(col_in);
               ev[0]  = make_rsp(c_lex_pkg::pair_kind(held_ff, b), '0, tline_ff,
                                 tcol_ff, tstart_ff, '0, c_lex_pkg::ERR_NONE);
            end else begin
               if (c_lex_pkg::is_single(held_ff)) begin
                  ev[0] = make_rsp(c_lex_pkg::KIND_SINGLE, 64'(held_ff), tline_ff,
                                   tcol_ff, tstart_ff, '0, c_lex_pkg::ERR_NONE);
               end else begin
                  ev[0] = make_rsp(c_lex_pkg::KIND_END, 64'(held_ff), tline_ff,
                                   tcol_ff, tstart_ff, '0, c_lex_pkg::ERR_UNKNOWN);
               end
               go_idle = 1'b1;
            end
         end
         default: begin
            mode_in = M_IDLE;
            go_idle = 1'b1;
         end
      endcase

      // start a new token or skip whitespace
      if (go_idle) begin
         if (c_lex_pkg::is_space(b)) begin
            if (b == c_lex_pkg::CH_NL) begin
               line_in = sat_inc(line_in);
               col_in  = CW'(1);
            end else begin
               col_in = sat_inc(col_in);
            end
         end else begin
            tline_in  = line_in;
            tcol_in   = col_in;
            tstart_in = off_ff;
            if (b == c_lex_pkg::CH_SLASH) begin
               mode_in = M_SLASH;
            end else begin
               col_in = sat_inc(col_in);
               if (c_lex_pkg::is_digit(b)) begin
                  acc_in  = 64'(b - c_lex_pkg::CH_ZERO);
                  mode_in = M_NUMBER;
               end else if (b == c_lex_pkg::CH_QUOTE) begin
                  mode_in = M_CHAR_OPEN;
               end else if (b == c_lex_pkg::CH_DQUOTE) begin
                  mode_in = M_STRING;
               end else if (c_lex_pkg::is_alpha(b)) begin
                  kbuf_in                = '0;
                  kbuf_in[KB_W-1 -: 8]   = b;
                  klen_in                = KL_W'(1);
                  mode_in                = M_IDENT;
               end else if (c_lex_pkg::is_pair_first(b)) begin
                  held_in = b;
                  mode_in = M_OPFIRST;
               end else begin
                  ev_vld[1] = 1'b1;
                  if (c_lex_pkg::is_single(b)) begin
                     ev[1] = make_rsp(c_lex_pkg::KIND_SINGLE, 64'(b), tline_in,
                                      tcol_in, tstart_in, '0, c_lex_pkg::ERR_NONE);
                  end else begin
                     ev[1] = make_rsp(c_lex_pkg::KIND_END, 64'(b), tline_in,
                                      tcol_in, tstart_in, '0, c_lex_pkg::ERR_UNKNOWN);
                  end
               end
            end
         end
      end

      off_in  = off_in + P'(1);
      prev_in = b;

      // end of text: flush the pending token, add the end token, start over
      if (req.is_last) begin
         ev_vld[2] = 1'b1;
         case (mode_in)
            M_SLASH: begin
               col_in = sat_inc(col_in);
               ev[2]  = make_rsp(c_lex_pkg::KIND_SINGLE, 64'(c_lex_pkg::CH_SLASH),
                                 tline_in, tcol_in, tstart_in, '0, c_lex_pkg::ERR_NONE);
            end
            M_BLOCK, M_BLOCK_STAR: begin
               ev[2] = make_rsp(c_lex_pkg::KIND_END, '0, tline_in, tcol_in,
                                tstart_in, '0, c_lex_pkg::ERR_COMMENT);
            end
            M_NUMBER: begin
               ev[2] = make_rsp(c_lex_pkg::KIND_INT, acc_in, tline_in, tcol_in,
                                tstart_in, '0, c_lex_pkg::ERR_NONE);
            end
            M_IDENT: begin
               ev[2] = make_rsp(ident_kind(kbuf_in, klen_in), '0, tline_in, tcol_in,
                                tstart_in, off_in - tstart_in, c_lex_pkg::ERR_NONE);
            end
            M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: begin
               ev[2] = make_rsp(c_lex_pkg::KIND_END, '0, tline_in, tcol_in,
                                tstart_in, '0, c_lex_pkg::ERR_CHAR);
            end
            M_STRING: begin
               ev[2] = make_rsp(c_lex_pkg::KIND_END, '0, tline_in, tcol_in,
                                tstart_in, '0, c_lex_pkg::ERR_STRING);
            end
            M_OPFIRST: begin
               if (c_lex_pkg::is_single(held_in)) begin
                  ev[2] = make_rsp(c_lex_pkg::KIND_SINGLE, 64'(held_in), tline_in,
                                   tcol_in, tstart_in, '0, c_lex_pkg::ERR_NONE);
               end else begin
                  ev[2] = make_rsp(c_lex_pkg::KIND_END, 64'(held_in), tline_in,
                                   tcol_in, tstart_in, '0, c_lex_pkg::ERR_UNKNOWN);
               end
            end
            default: begin
               ev_vld[2] = 1'b0;
            end
         endcase

         end_line = line_in;
         end_col  = col_in;
         if (b == c_lex_pkg::CH_NL) begin
            if (end_line != '0) begin
               end_line = end_line - CW'(1);
            end
            end_col = CW'(1);
         end
         ev_vld[3] = 1'b1;
         ev[3]     = make_rsp(c_lex_pkg::KIND_END, '0, end_line, end_col, off_in, '0,
                              c_lex_pkg::ERR_NONE);

         mode_in   = M_IDLE;
         line_in   = CW'(1);
         col_in    = CW'(1);
         tline_in  = '0;
         tcol_in   = '0;
         off_in    = '0;
         tstart_in = '0;
         acc_in    = '0;
         held_in   = '0;
         prev_in   = '0;
         kbuf_in   = '0;
         klen_in   = '0;
      end
   end

   // pack up to three results in order and mark the last one
   always_comb begin
      batch = '0;
      n     = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (ev_vld[i] && n != 2'd3) begin
            batch.item[n] = ev[i];
            n             = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         batch.item[n - 2'd1].last_of_run = 1'b1;
      end
      batch.count = n;
   end

   // advance the lexer state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         line_ff   <= CW'(1);
         col_ff    <= CW'(1);
         tline_ff  <= '0;
         tcol_ff   <= '0;
         off_ff    <= '0;
         tstart_ff <= '0;
         acc_ff    <= '0;
         held_ff   <= '0;
         prev_ff   <= '0;
         kbuf_ff   <= '0;
         klen_ff   <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         off_ff    <= off_in;
         tstart_ff <= tstart_in;
         acc_ff    <= acc_in;
         held_ff   <= held_in;
         prev_ff   <= prev_in;
         kbuf_ff   <= kbuf_in;
         klen_ff   <= klen_in;
      end
   end

endmodule

>>> src/c_lex_outq.sv
// ----------------------------------------------------------------------------
// C subset lexer result buffer
// Holds the results of one byte and hands them out one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module c_lex_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  c_lex_pkg::lex_batch_type batch,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output c_lex_pkg::lex_rsp_type   rsp_data
);

   c_lex_pkg::lex_rsp_type [c_lex_pkg::SLOTS-1:0] slot_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] head_ff, head_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // free once the last pending result leaves this cycle
   assign room      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   // advance the head on a pop, reload on a new batch
   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         if (cnt_ff != 2'd1) begin
            head_in = head_ff + 2'd1;
         end
      end
      if (load) begin
         cnt_in  = batch.count;
         head_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         head_ff <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= batch.item;
      end
   end

endmodule

>>> src/c_lex_subset_top_placeholder.sv
// ----------------------------------------------------------------------------
// C subset lexer input register
// Holds one request until the result buffer can take its results.
// ----------------------------------------------------------------------------
module c_lex_inreg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  c_lex_pkg::lex_req_type req_data,
   input  logic                   room,
   output logic                   advance,
   output c_lex_pkg::lex_req_type held
);

   logic                   vld_ff, vld_in;
   c_lex_pkg::lex_req_type req_ff;
   logic                   take;

   assign advance   = vld_ff && room;
   assign req_stall = vld_ff && !room;
   assign take      = req_valid && !req_stall;
   assign held      = req_ff;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the request payload
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
   end

endmodule
